[rtl/tagged_integer_record_packer_assert.svh]
// Assertion macros used by the checker file tip_chk.
`ifndef TAGGED_INTEGER_RECORD_PACKER_ASSERT_SVH
`define TAGGED_INTEGER_RECORD_PACKER_ASSERT_SVH

// Checked only while out of reset.
`define TIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TIP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tip_pkg.sv]
`timescale 1ns / 1ps

package tip_pkg;

  localparam int MoveW    = 16;
  localparam int CountW   = 32;
  localparam int CoordW   = 4;
  localparam int ByteW    = 8;
  localparam int MaxBytes = 20;
  localparam int BufW     = MaxBytes * ByteW;
  localparam int BitsW    = 8;
  localparam int NbW      = 5;

  localparam logic signed [CountW-1:0] ByteMin = -32'sd128;
  localparam logic signed [CountW-1:0] ByteLim = 32'sd127;
  localparam logic signed [CountW-1:0] HalfMin = -32'sd32768;
  localparam logic signed [CountW-1:0] HalfLim = 32'sd32767;

  typedef enum logic [1:0] {
    TAG_ZERO = 2'd0,
    TAG_BYTE = 2'd1,
    TAG_HALF = 2'd2,
    TAG_WORD = 2'd3
  } size_tag_t;

  typedef struct packed {
    logic [MoveW-1:0]         move_code;
    logic signed [CountW-1:0] score;
    logic signed [CountW-1:0] wins;
    logic signed [CountW-1:0] draws;
    logic signed [CountW-1:0] losses;
    logic                     valid_req;
    logic                     mirror_ud;
    logic                     mirror_lr;
    logic [CoordW-1:0]        board_rows;
    logic [CoordW-1:0]        board_cols;
  } rec_t;

  typedef struct packed {
    logic [BufW-1:0] bits;
    logic [NbW-1:0]  nbytes;
  } packed_rec_t;

  function automatic logic [CoordW-1:0] reflect(input logic [CoordW-1:0] size,
                                                input logic [CoordW-1:0] coord);
    reflect = size - CoordW'(1) - coord;
  endfunction

  function automatic size_tag_t size_tag(input logic signed [CountW-1:0] v);
    priority if (v == '0) begin
      size_tag = TAG_ZERO;
    end else if (v >= ByteMin && v < ByteLim) begin
      size_tag = TAG_BYTE;
    end else if (v >= HalfMin && v < HalfLim) begin
      size_tag = TAG_HALF;
    end else begin
      size_tag = TAG_WORD;
    end
  endfunction

endpackage

[rtl/tip_pack.sv]
`timescale 1ns / 1ps

module tip_pack import tip_pkg::*; (
  input  rec_t        rec,
  output packed_rec_t pk
);

  logic signed [CountW-1:0] cnts [4];

  assign cnts[0] = rec.score;
  assign cnts[1] = rec.wins;
  assign cnts[2] = rec.draws;
  assign cnts[3] = rec.losses;

  always_comb begin
    logic [CoordW-1:0] fr, fc, tr, tc;
    logic [BufW-1:0]   acc;
    logic [BitsW-1:0]  nbits;
    logic [BitsW-1:0]  sh;
    size_tag_t         tag;
    fr = rec.move_code[15:12];
    fc = rec.move_code[11:8];
    tr = rec.move_code[7:4];
    tc = rec.move_code[3:0];
    if (rec.mirror_ud) begin
      fr = reflect(rec.board_rows, fr);
      tr = reflect(rec.board_rows, tr);
    end
    // Both mirrors together reflect the columns twice, which cancels.
    if (rec.mirror_ud ^ rec.mirror_lr) begin
      fc = reflect(rec.board_cols, fc);
      tc = reflect(rec.board_cols, tc);
    end
    acc   = BufW'({fr, fc, tr, tc});
    nbits = BitsW'(MoveW);
    for (int i = 0; i < 4; i++) begin
      tag = size_tag(cnts[i]);
      unique case (tag)
        TAG_ZERO: begin
          acc   = {acc[BufW-3:0], tag};
          nbits = nbits + BitsW'(2);
        end
        TAG_BYTE: begin
          acc   = {acc[BufW-11:0], tag, cnts[i][7:0]};
          nbits = nbits + BitsW'(10);
        end
        TAG_HALF: begin
          acc   = {acc[BufW-19:0], tag, cnts[i][15:0]};
          nbits = nbits + BitsW'(18);
        end
        TAG_WORD: begin
          acc   = {acc[BufW-35:0], tag, cnts[i]};
          nbits = nbits + BitsW'(34);
        end
        default: begin
          acc   = acc;
          nbits = nbits;
        end
      endcase
    end
    acc   = {acc[BufW-2:0], rec.valid_req};
    nbits = nbits + BitsW'(1);
    sh        = BitsW'(BufW) - nbits;
    pk.bits   = acc << sh;
    pk.nbytes = NbW'((nbits + BitsW'(7)) >> 3);
  end

endmodule

[rtl/tip_ser.sv]
`timescale 1ns / 1ps

module tip_ser import tip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld_valid,
  input  packed_rec_t       pk,
  output logic              ld_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ByteW-1:0]  out_byte,
  output logic              out_last
);

  logic [BufW-1:0] buf_r, buf_nxt;
  logic [NbW-1:0]  cnt_r, cnt_nxt;
  logic            valid_r, valid_nxt;
  logic            beat;

  assign out_valid = valid_r;
  assign out_byte  = buf_r[BufW-1 -: ByteW];
  assign out_last  = (cnt_r == NbW'(1));
  assign beat      = valid_r && out_ready;
  assign ld_take   = ld_valid && (!valid_r || (beat && out_last));

  always_comb begin
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    if (ld_take) begin
      buf_nxt   = pk.bits;
      cnt_nxt   = pk.nbytes;
      valid_nxt = 1'b1;
    end else if (beat) begin
      buf_nxt = {buf_r[BufW-ByteW-1:0], ByteW'(0)};
      cnt_nxt = cnt_r - NbW'(1);
      if (out_last) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

[rtl/tagged_integer_record_packer.sv]
`timescale 1ns / 1ps

// Packs one record into 4 to 20 bytes, sent MSB first with out_last on the final
// beat. A record occupies the byte channel for one beat per byte, set by the
// byte-wide output shift register. An accepted record is registered, packed
// combinationally and loaded into the shift register once that is free, and its
// first byte is then on the output; the next record is taken while the current
// one drains.

module tagged_integer_record_packer import tip_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MoveW-1:0]         in_move_code,
  input  logic signed [CountW-1:0] in_score,
  input  logic signed [CountW-1:0] in_wins,
  input  logic signed [CountW-1:0] in_draws,
  input  logic signed [CountW-1:0] in_losses,
  input  logic                     in_valid_req,
  input  logic                     in_mirror_ud,
  input  logic                     in_mirror_lr,
  input  logic [CoordW-1:0]        in_board_rows,
  input  logic [CoordW-1:0]        in_board_cols,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ByteW-1:0]         out_byte,
  output logic                     out_last
);

  rec_t        rec_r, rec_nxt;
  logic        a_valid_r, a_valid_nxt;
  logic        ld_take;
  logic        in_beat;
  packed_rec_t pk;

  assign in_ready = !a_valid_r || ld_take;
  assign in_beat  = in_valid && in_ready;

  always_comb begin
    rec_nxt     = rec_r;
    a_valid_nxt = a_valid_r;
    if (in_beat) begin
      rec_nxt.move_code  = in_move_code;
      rec_nxt.score      = in_score;
      rec_nxt.wins       = in_wins;
      rec_nxt.draws      = in_draws;
      rec_nxt.losses     = in_losses;
      rec_nxt.valid_req  = in_valid_req;
      rec_nxt.mirror_ud  = in_mirror_ud;
      rec_nxt.mirror_lr  = in_mirror_lr;
      rec_nxt.board_rows = in_board_rows;
      rec_nxt.board_cols = in_board_cols;
      a_valid_nxt        = 1'b1;
    end else if (ld_take) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  tip_pack u_pack (
    .rec (rec_r),
    .pk  (pk)
  );

  tip_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (a_valid_r),
    .pk        (pk),
    .ld_take   (ld_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

[rtl/tip_chk.sv]
`timescale 1ns / 1ps

`include "tagged_integer_record_packer_assert.svh"

module tip_chk import tip_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ByteW-1:0] out_byte,
  input logic             out_last
);

  logic [NbW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic           beat;

  assign beat = out_valid && out_ready;

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    if (beat) begin
      byte_cnt_nxt = out_last ? '0 : byte_cnt_r + NbW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  `TIP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last), "stalled output beat changed")
  `TIP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid right after reset")
  `TIP_ASSERT(a_max_len, beat && byte_cnt_r == NbW'(MaxBytes - 1) |-> out_last, "record longer than the maximum")
  `TIP_ASSERT(a_min_len, beat && out_last |-> byte_cnt_r >= NbW'(3), "record shorter than four bytes")

endmodule

bind tagged_integer_record_packer tip_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

[tb/sv/tagged_integer_record_packer_checker.sv]
`timescale 1ns / 1ps

module tagged_integer_record_packer_checker import tip_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [MoveW-1:0]         in_move_code,
  input  logic signed [CountW-1:0] in_score,
  input  logic signed [CountW-1:0] in_wins,
  input  logic signed [CountW-1:0] in_draws,
  input  logic signed [CountW-1:0] in_losses,
  input  logic                     in_valid_req,
  input  logic                     in_mirror_ud,
  input  logic                     in_mirror_lr,
  input  logic [CoordW-1:0]        in_board_rows,
  input  logic [CoordW-1:0]        in_board_cols,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [ByteW-1:0]         out_byte,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } packed_beat_t;

  packed_beat_t byte_stream_q[$];
  packed_beat_t want;
  int           beat_index;

  task automatic report_mismatch(input string msg);
    $display("[%0t] beat %0d: %s", $realtime, beat_index, msg);
    fail_count++;
  endtask

  function automatic size_tag_t count_size(input logic signed [CountW-1:0] v);
    if (v == 0) begin
      return TAG_ZERO;
    end else if (v >= -32'sd128 && v < 32'sd127) begin
      return TAG_BYTE;
    end else if (v >= -32'sd32768 && v < 32'sd32767) begin
      return TAG_HALF;
    end
    return TAG_WORD;
  endfunction

  // Builds the whole bit string right-aligned, then left-aligns it so that
  // the first bit sits in bit 7 of the first byte and the pad bits are zero.
  function automatic void pack_record(input rec_t r);
    logic [BufW-1:0]          acc;
    logic [CoordW-1:0]        fr, fc, tr, tc;
    logic signed [CountW-1:0] counts [4];
    size_tag_t                tag;
    int                       nbits, nbytes, width;
    packed_beat_t             b;
    fr = r.move_code[15:12];
    fc = r.move_code[11:8];
    tr = r.move_code[7:4];
    tc = r.move_code[3:0];
    if (r.mirror_ud) begin
      fr = r.board_rows - 4'd1 - fr;
      tr = r.board_rows - 4'd1 - tr;
      fc = r.board_cols - 4'd1 - fc;
      tc = r.board_cols - 4'd1 - tc;
    end
    if (r.mirror_lr) begin
      fc = r.board_cols - 4'd1 - fc;
      tc = r.board_cols - 4'd1 - tc;
    end
    acc = BufW'({fr, fc, tr, tc});
    nbits = MoveW;
    counts[0] = r.score;
    counts[1] = r.wins;
    counts[2] = r.draws;
    counts[3] = r.losses;
    for (int i = 0; i < 4; i++) begin
      tag = count_size(counts[i]);
      acc = (acc << 2) | BufW'(tag);
      nbits += 2;
      case (tag)
        TAG_BYTE: width = 8;
        TAG_HALF: width = 16;
        TAG_WORD: width = 32;
        default:  width = 0;
      endcase
      if (width > 0) begin
        acc = (acc << width) | (BufW'(counts[i]) & ((BufW'(1) << width) - BufW'(1)));
        nbits += width;
      end
    end
    acc = (acc << 1) | BufW'(r.valid_req);
    nbits += 1;
    nbytes = (nbits + 7) / 8;
    acc = acc << (nbytes * 8 - nbits);
    for (int k = 0; k < nbytes; k++) begin
      b.data = acc[(nbytes - 1 - k) * ByteW +: ByteW];
      b.last = (k == nbytes - 1);
      byte_stream_q.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (byte_stream_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h arrived with no record pending", out_byte));
        end else begin
          want = byte_stream_q.pop_front();
          if (out_byte !== want.data) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("out_last %0b, expected %0b", out_last, want.last));
          end
        end
        beat_index++;
      end
      if (in_valid && in_ready) begin
        pack_record({in_move_code, in_score, in_wins, in_draws, in_losses, in_valid_req,
                     in_mirror_ud, in_mirror_lr, in_board_rows, in_board_cols});
      end
    end
    pending <= byte_stream_q.size();
  end

endmodule

[tb/sv/tb_tagged_integer_record_packer.sv]
`timescale 1ns / 1ps

module tb_tagged_integer_record_packer;
  import tip_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int PhaseRecords = 30;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic [MoveW-1:0]         in_move_code  = '0;
  logic signed [CountW-1:0] in_score      = '0;
  logic signed [CountW-1:0] in_wins       = '0;
  logic signed [CountW-1:0] in_draws      = '0;
  logic signed [CountW-1:0] in_losses     = '0;
  logic                     in_valid_req  = 1'b0;
  logic                     in_mirror_ud  = 1'b0;
  logic                     in_mirror_lr  = 1'b0;
  logic [CoordW-1:0]        in_board_rows = '0;
  logic [CoordW-1:0]        in_board_cols = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic [ByteW-1:0]         out_byte;
  logic                     out_last;
  int                       fail_count;
  int                       pending;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  always #5 clk = ~clk;

  tagged_integer_record_packer dut (.*);

  tagged_integer_record_packer_checker checker_i (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic rec_t mk_rec(input logic [MoveW-1:0] mv,
                                  input logic signed [CountW-1:0] s, w, d, l,
                                  input logic vr, ud, lr,
                                  input logic [CoordW-1:0] rows, cols);
    rec_t r;
    r.move_code  = mv;
    r.score      = s;
    r.wins       = w;
    r.draws      = d;
    r.losses     = l;
    r.valid_req  = vr;
    r.mirror_ud  = ud;
    r.mirror_lr  = lr;
    r.board_rows = rows;
    r.board_cols = cols;
    return r;
  endfunction

  // Counts are weighted toward the size-tag boundaries.
  function automatic logic signed [CountW-1:0] random_count();
    case ($urandom_range(5))
      0: return '0;
      1: begin
        case ($urandom_range(11))
          0:  return -32'sd2147483648;
          1:  return -32'sd32769;
          2:  return -32'sd32768;
          3:  return -32'sd129;
          4:  return -32'sd128;
          5:  return -32'sd1;
          6:  return 32'sd1;
          7:  return 32'sd126;
          8:  return 32'sd127;
          9:  return 32'sd32766;
          10: return 32'sd32767;
          default: return 32'sd2147483647;
        endcase
      end
      2: return CountW'($signed(8'($urandom)));
      3: return CountW'($signed(16'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  function automatic rec_t random_record();
    return mk_rec(MoveW'($urandom), random_count(), random_count(), random_count(),
                  random_count(), 1'($urandom), 1'($urandom), 1'($urandom),
                  CoordW'($urandom), CoordW'($urandom));
  endfunction

  task automatic send_record(input rec_t r);
    in_valid      <= 1'b1;
    in_move_code  <= r.move_code;
    in_score      <= r.score;
    in_wins       <= r.wins;
    in_draws      <= r.draws;
    in_losses     <= r.losses;
    in_valid_req  <= r.valid_req;
    in_mirror_ud  <= r.mirror_ud;
    in_mirror_lr  <= r.mirror_lr;
    in_board_rows <= r.board_rows;
    in_board_cols <= r.board_cols;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (phase == 0) begin
        send_record(mk_rec(16'h0000, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 4'd8, 4'd8));
        send_record(mk_rec(16'hffff, -32'sd2147483648, -32'sd2147483648,
                           -32'sd2147483648, -32'sd2147483648, 1'b1, 1'b0, 1'b0,
                           4'd15, 4'd15));
        send_record(mk_rec(16'h1234, 32'sd127, 32'sd126, -32'sd128, -32'sd129,
                           1'b1, 1'b0, 1'b0, 4'd8, 4'd8));
        send_record(mk_rec(16'h5678, 32'sd32767, 32'sd32766, -32'sd32768, -32'sd32769,
                           1'b0, 1'b0, 1'b0, 4'd8, 4'd8));
        send_record(mk_rec(16'h9abc, 32'sd2147483647, 32'sd1, -32'sd1, 0,
                           1'b1, 1'b0, 1'b0, 4'd10, 4'd10));
        send_record(mk_rec(16'h1234, 32'sd128, -32'sd127, 32'sd255, -32'sd256,
                           1'b1, 1'b1, 1'b0, 4'd8, 4'd8));
        send_record(mk_rec(16'h1234, 0, 32'sd5, 0, 32'sd70000,
                           1'b0, 1'b0, 1'b1, 4'd8, 4'd8));
        send_record(mk_rec(16'h1234, -32'sd1, 0, 32'sd1, 0,
                           1'b1, 1'b1, 1'b1, 4'd8, 4'd8));
        send_record(mk_rec(16'hfedc, 32'sd100, 32'sd200, 32'sd300, 32'sd400,
                           1'b1, 1'b1, 1'b0, 4'd3, 4'd5));
        send_record(mk_rec(16'h0f0f, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1, 4'd0, 4'd0));
        send_record(mk_rec(16'h0000, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0, 4'd0, 4'd0));
        send_record(mk_rec(16'hffff, 32'sd2147483647, 32'sd2147483647,
                           32'sd2147483647, 32'sd2147483647, 1'b1, 1'b1, 1'b1,
                           4'd15, 4'd15));
        send_record(mk_rec(16'h8421, 32'sd1, 0, 0, 0, 1'b1, 1'b0, 1'b1, 4'd1, 4'd15));
        send_record(mk_rec(16'h7777, 0, 0, 0, -32'sd2147483648, 1'b0, 1'b1, 1'b0,
                           4'd15, 4'd1));
        wait_drained();
      end
      for (int n = 0; n < PhaseRecords; n++) begin
        send_record(random_record());
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
